// ===== rtl/gln_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gln_pkg
// Shared types, register indexes, hash constants and helper functions for the
// 2D gradient lattice noise block.
// ----------------------------------------------------------------------------
package gln_pkg;

  // Coordinate fraction bits used by default
  localparam int COORD_FRAC_BITS_DEF = 16;

  // Register indexes on the write port
  localparam logic [2:0] CFG_SEED        = 3'd0;
  localparam logic [2:0] CFG_SCALE       = 3'd1;
  localparam logic [2:0] CFG_AMPLITUDE   = 3'd2;
  localparam logic [2:0] CFG_NOISE_MODE  = 3'd3;
  localparam logic [2:0] CFG_BILLOW_BIAS = 3'd4;
  localparam logic [2:0] CFG_OFFSET_X    = 3'd5;
  localparam logic [2:0] CFG_OFFSET_Y    = 3'd6;

  // Noise shaping modes; any other code gives plain gradient noise
  localparam logic [1:0] MODE_PLAIN  = 2'd0;
  localparam logic [1:0] MODE_RIDGE  = 2'd1;
  localparam logic [1:0] MODE_BILLOW = 2'd2;

  // Hash constants
  localparam logic [31:0] LCG_MUL   = 32'd1664525;
  localparam logic [31:0] LCG_ADD   = 32'd1013904223;
  localparam logic [31:0] GOLD_LO   = 32'h85EBCA87;
  localparam logic [31:0] GOLD_HI   = 32'h9E3779B1;
  localparam logic [31:0] MIX_MUL_A = 32'h7feb352d;
  localparam logic [31:0] MIX_MUL_B = 32'h846ca68b;

  // Reset values of the registers
  localparam logic [31:0] SEED_RST  = 32'd1337;
  localparam logic [23:0] SCALE_RST = 24'd65536;
  localparam logic [15:0] AMP_RST   = 16'd4096;

  // Request payloads
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
  } pos_t;

  typedef struct packed {
    logic signed [15:0] noise_value;
    logic               saturated;
  } noise_t;

  // One LCG step, modulo 2^32
  function automatic logic [31:0] lcg(input logic [31:0] h);
    lcg = h * LCG_MUL + LCG_ADD;
  endfunction

  // Corner contribution: +-u +- 2v, picked by two hash bits
  function automatic logic signed [19:0] corner(input logic [1:0] sel,
                                                input logic signed [17:0] dx,
                                                input logic signed [17:0] dy);
    logic signed [19:0] ex;
    logic signed [19:0] ey;
    logic signed [19:0] u;
    logic signed [19:0] v;
    logic signed [19:0] a;
    logic signed [19:0] b;
    ex = {{2{dx[17]}}, dx};
    ey = {{2{dy[17]}}, dy};
    u = sel[1] ? ey : ex;
    v = sel[1] ? ex : ey;
    a = sel[0] ? -u : u;
    b = sel[1] ? -(v <<< 1) : (v <<< 1);
    corner = a + b;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/gradient_lattice_noise_2d.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gradient_lattice_noise_2d
// Seeded 2D gradient lattice noise with plain, ridge and billow shaping.
// ----------------------------------------------------------------------------
// The block takes one position request per clock while the output is not
// stalled and returns one noise sample for each. Every stage holds one
// multiply at most: offset add, scale multiply in two partial products,
// lattice split, the seven multiply hash chain (run for all four corners
// side by side), smoothstep, two bilinear blend levels, shaping and the
// amplitude gain. When the output is stalled the whole pipeline holds, so
// a stall drops and repeats nothing. The seed-derived hash word is ready
// after a seed write well before any new request reaches its hash stage.
module gradient_lattice_noise_2d #(
  parameter int COORD_FRAC_BITS = gln_pkg::COORD_FRAC_BITS_DEF
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  pos_valid,
  output logic                 pos_stall,
  input  gln_pkg::pos_t        pos,
  output logic                 noise_valid,
  input  wire                  noise_stall,
  output gln_pkg::noise_t      noise,
  input  wire                  cfg_write,
  input  wire  [2:0]           cfg_index,
  input  wire  [31:0]          cfg_data
);

  localparam int NSTAGE = 18;
  localparam int F = COORD_FRAC_BITS;

  // Configuration registers
  logic [31:0]        seed;
  logic [23:0]        scale;
  logic signed [15:0] amplitude;
  logic [1:0]         noise_mode;
  logic signed [15:0] billow_bias;
  logic signed [31:0] offset_x;
  logic signed [31:0] offset_y;

  // Seed-derived hash word
  logic [63:0] seed_prod_lo;
  logic [31:0] seed_prod_hi;
  logic [31:0] seed_hi;

  // Pipeline control
  logic [NSTAGE-1:0] vld;
  logic              adv;
  logic              accept;

  // Stage registers
  logic signed [32:0] sum1 [2];
  logic signed [45:0] pp_lo2 [2];
  logic signed [45:0] pp_hi2 [2];
  logic [31:0]        cell3 [2];
  logic [1:0][15:0]   frac3;
  logic [31:0]        y0_4, y1_4;
  logic [31:0]        ha4 [2];
  logic [15:0]        f2_4 [2];
  logic [17:0]        t4 [2];
  logic [1:0][15:0]   frac_pipe [7];
  logic [1:0][17:0]   s_pipe [6];
  logic [3:0][31:0]   h5, h6, h7, h8, h9, h10;
  logic signed [19:0] n11 [4];
  logic [17:0]        sx11, sy11, sy12, sy13;
  logic signed [19:0] n00_12, n01_12;
  logic signed [39:0] pr0_12, pr1_12;
  logic signed [20:0] n0_13, n1_13, n0_14;
  logic signed [40:0] prn_14;
  logic signed [20:0] n15;
  logic signed [22:0] shaped16;
  logic signed [38:0] prod17;
  gln_pkg::noise_t    out_q;

  // Combinational helpers
  logic signed [57:0] full3 [2];
  logic signed [71:0] pe3 [2];
  logic [31:0]        cell_c [2];
  logic [F-1:0]       fraw [2];
  logic [15:0]        fq [2];
  logic [3:0][1:0]    sel11;
  logic signed [17:0] dx0, dx1, dy0, dy1;
  logic signed [23:0] bl0, bl1;
  logic signed [21:0] dn13;
  logic signed [24:0] bln;
  logic signed [20:0] mag;
  logic signed [22:0] ridge, billow, shaped_next;
  logic signed [22:0] q18;
  gln_pkg::noise_t    out_next;

  // Handshake: the whole pipeline advances unless the output is stalled
  assign adv         = !(vld[NSTAGE-1] && noise_stall);
  assign pos_stall   = !adv;
  assign accept      = pos_valid && adv;
  assign noise_valid = vld[NSTAGE-1];
  assign noise       = out_q;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      seed        <= gln_pkg::SEED_RST;
      scale       <= gln_pkg::SCALE_RST;
      amplitude   <= gln_pkg::AMP_RST;
      noise_mode  <= gln_pkg::MODE_PLAIN;
      billow_bias <= '0;
      offset_x    <= '0;
      offset_y    <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        gln_pkg::CFG_SEED:        seed        <= cfg_data;
        gln_pkg::CFG_SCALE:       scale       <= cfg_data[23:0];
        gln_pkg::CFG_AMPLITUDE:   amplitude   <= cfg_data[15:0];
        gln_pkg::CFG_NOISE_MODE:  noise_mode  <= cfg_data[1:0];
        gln_pkg::CFG_BILLOW_BIAS: billow_bias <= cfg_data[15:0];
        gln_pkg::CFG_OFFSET_X:    offset_x    <= cfg_data;
        gln_pkg::CFG_OFFSET_Y:    offset_y    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Derive high word of seed times the golden constant from registered partial products
  always_ff @(posedge clk) begin
    seed_prod_lo <= 64'(seed) * 64'(gln_pkg::GOLD_LO);
    seed_prod_hi <= seed * gln_pkg::GOLD_HI;
    seed_hi      <= seed_prod_lo[63:32] + seed_prod_hi;
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NSTAGE-2:0], accept};
    end
  end

  // Lattice split of the scaled coordinate
  always_comb begin
    for (int a = 0; a < 2; a++) begin
      full3[a]  = (58'(pp_hi2[a]) <<< 12) + 58'(pp_lo2[a]);
      pe3[a]    = 72'($signed(full3[a][57:16]));
      cell_c[a] = pe3[a][F +: 32];
      fraw[a]   = pe3[a][F-1:0];
    end
  end

  // Bring the fraction to 16 bits
  generate
    if (F >= 16) begin : g_frac_trunc
      assign fq[0] = fraw[0][F-1 -: 16];
      assign fq[1] = fraw[1][F-1 -: 16];
    end else begin : g_frac_ext
      assign fq[0] = {fraw[0], {(16-F){1'b0}}};
      assign fq[1] = {fraw[1], {(16-F){1'b0}}};
    end
  endgenerate

  // Corner offsets and gradient picks
  always_comb begin
    dx0 = $signed({2'b00, frac_pipe[6][0]});
    dy0 = $signed({2'b00, frac_pipe[6][1]});
    dx1 = dx0 - 18'sd65536;
    dy1 = dy0 - 18'sd65536;
    for (int c = 0; c < 4; c++) begin
      sel11[c] = h10[c][1:0] ^ h10[c][17:16];
    end
  end

  // Blend and shaping arithmetic
  always_comb begin
    bl0  = 24'(n00_12) + pr0_12[39:16];
    bl1  = 24'(n01_12) + pr1_12[39:16];
    dn13 = 22'(n1_13) - 22'(n0_13);
    bln  = 25'(n0_14) + prn_14[40:16];
    mag  = n15[20] ? -n15 : n15;
    ridge  = 23'sd65536 - (23'(mag) <<< 1);
    billow = 23'(mag) + (23'(billow_bias) <<< 4);
    if (billow > 23'sd65536) begin
      billow = 23'sd65536;
    end
    if (billow < -23'sd65536) begin
      billow = -23'sd65536;
    end
    case (noise_mode)
      gln_pkg::MODE_RIDGE:  shaped_next = ridge;
      gln_pkg::MODE_BILLOW: shaped_next = billow;
      default:              shaped_next = 23'(n15);
    endcase
  end

  // Scale the gain product back and clip to Q4.12
  always_comb begin
    q18 = prod17[38:16];
    out_next.saturated   = 1'b0;
    out_next.noise_value = q18[15:0];
    if (q18 > 23'sd32767) begin
      out_next.noise_value = 16'sh7fff;
      out_next.saturated   = 1'b1;
    end else if (q18 < -23'sd32768) begin
      out_next.noise_value = 16'sh8000;
      out_next.saturated   = 1'b1;
    end
  end

  // Datapath: every stage holds while the output is stalled
  always_ff @(posedge clk) begin
    if (adv) begin
      // Add offset
      sum1[0] <= 33'(pos.pos_x) + 33'(offset_x);
      sum1[1] <= 33'(pos.pos_y) + 33'(offset_y);
      // Scale in two partial products
      for (int a = 0; a < 2; a++) begin
        pp_lo2[a] <= sum1[a] * $signed({1'b0, scale[11:0]});
        pp_hi2[a] <= sum1[a] * $signed({1'b0, scale[23:12]});
      end
      // Split into cell and fraction
      cell3[0] <= cell_c[0];
      cell3[1] <= cell_c[1];
      frac3[0] <= fq[0];
      frac3[1] <= fq[1];
      // First hash step on x, smoothstep square
      y0_4  <= cell3[1];
      y1_4  <= cell3[1] + 32'd1;
      ha4[0] <= gln_pkg::lcg(cell3[0]);
      ha4[1] <= gln_pkg::lcg(cell3[0] + 32'd1);
      for (int a = 0; a < 2; a++) begin
        f2_4[a] <= 16'((32'(frac3[a]) * 32'(frac3[a])) >> 16);
        t4[a]   <= 18'd196608 - {1'b0, frac3[a], 1'b0};
      end
      frac_pipe[0] <= frac3;
      for (int k = 1; k < 7; k++) begin
        frac_pipe[k] <= frac_pipe[k-1];
      end
      // Mix in y, finish smoothstep
      for (int c = 0; c < 4; c++) begin
        h5[c] <= gln_pkg::lcg(ha4[c%2] ^ ((c/2 == 1) ? y1_4 : y0_4));
      end
      for (int a = 0; a < 2; a++) begin
        s_pipe[0][a] <= 18'((34'(f2_4[a]) * 34'(t4[a])) >> 16);
      end
      for (int k = 1; k < 6; k++) begin
        s_pipe[k] <= s_pipe[k-1];
      end
      // Seed, seed high word, tag and avalanche
      for (int c = 0; c < 4; c++) begin
        h6[c]  <= gln_pkg::lcg(h5[c] ^ seed);
        h7[c]  <= gln_pkg::lcg(h6[c] ^ seed_hi);
        h8[c]  <= gln_pkg::lcg(h7[c]);
        h9[c]  <= (h8[c] ^ (h8[c] >> 16)) * gln_pkg::MIX_MUL_A;
        h10[c] <= (h9[c] ^ (h9[c] >> 15)) * gln_pkg::MIX_MUL_B;
      end
      // Corner values
      n11[0] <= gln_pkg::corner(sel11[0], dx0, dy0);
      n11[1] <= gln_pkg::corner(sel11[1], dx1, dy0);
      n11[2] <= gln_pkg::corner(sel11[2], dx0, dy1);
      n11[3] <= gln_pkg::corner(sel11[3], dx1, dy1);
      sx11   <= s_pipe[5][0];
      sy11   <= s_pipe[5][1];
      // Blend along x
      n00_12 <= n11[0];
      n01_12 <= n11[2];
      pr0_12 <= $signed({1'b0, sx11}) * (21'(n11[1]) - 21'(n11[0]));
      pr1_12 <= $signed({1'b0, sx11}) * (21'(n11[3]) - 21'(n11[2]));
      sy12   <= sy11;
      n0_13  <= bl0[20:0];
      n1_13  <= bl1[20:0];
      sy13   <= sy12;
      // Blend along y
      n0_14  <= n0_13;
      prn_14 <= $signed({1'b0, sy13}) * dn13;
      n15    <= bln[20:0];
      // Shape, apply gain, clip
      shaped16 <= shaped_next;
      prod17   <= shaped16 * amplitude;
      out_q    <= out_next;
    end
  end

  // A taken request enters the first stage
  assert property (@(posedge clk) disable iff (rst)
    (pos_valid && !pos_stall) |=> vld[0])
    else $error("accepted request did not enter the pipeline");

  // A stalled output freezes every stage's valid bit
  assert property (@(posedge clk) disable iff (rst)
    (noise_valid && noise_stall) |=> $stable(vld))
    else $error("pipeline moved during an output stall");

  // A clipped result sits on a rail
  assert property (@(posedge clk) disable iff (rst)
    (noise_valid && noise.saturated) |->
      (noise.noise_value == 16'sh7fff || noise.noise_value == 16'sh8000))
    else $error("saturated flag set on an in-range value");

endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gradient lattice noise testbench
// Drives position requests through the noise block under several register
// settings and idle patterns, predicts each noise sample in fixed point and
// compares every returned request field by field, in order.
// ----------------------------------------------------------------------------

class noise_scoreboard;
  gln_pkg::noise_t pending_samples[$];
  int mismatches;
  int checked;

  // Queue the predicted sample for an accepted position
  function void note_position(gln_pkg::noise_t predicted);
    pending_samples.push_back(predicted);
  endfunction

  // Compare a returned sample with the oldest prediction
  function void check_sample(gln_pkg::noise_t got);
    gln_pkg::noise_t want;
    if (pending_samples.size() == 0) begin
      report_mismatch("sample with no pending prediction", 0, got.noise_value);
      return;
    end
    want = pending_samples.pop_front();
    checked++;
    if (got.noise_value !== want.noise_value)
      report_mismatch("noise_value", want.noise_value, got.noise_value);
    if (got.saturated !== want.saturated)
      report_mismatch("saturated", want.saturated, got.saturated);
  endfunction

  function void report_mismatch(string what, longint want, longint got);
    mismatches++;
    if (mismatches <= 40)
      $display("mismatch %0d: %s expected %0d got %0d", mismatches, what, want, got);
  endfunction
endclass

module testbench;

  localparam int LATENCY = 18;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic pos_valid = 1'b0;
  logic pos_stall;
  gln_pkg::pos_t pos = '0;
  logic noise_valid;
  logic noise_stall = 1'b0;
  gln_pkg::noise_t noise;
  logic cfg_write = 1'b0;
  logic [2:0] cfg_index = gln_pkg::CFG_SEED;
  logic [31:0] cfg_data = '0;

  gradient_lattice_noise_2d dut (
    .clk(clk), .rst(rst),
    .pos_valid(pos_valid), .pos_stall(pos_stall), .pos(pos),
    .noise_valid(noise_valid), .noise_stall(noise_stall), .noise(noise),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the register file
  logic [31:0] seed_reg;
  logic [23:0] scale_reg;
  logic signed [15:0] amp_reg;
  logic [1:0] mode_reg;
  logic signed [15:0] bias_reg;
  logic signed [31:0] offx_reg;
  logic signed [31:0] offy_reg;

  noise_scoreboard board;
  int sender_idle_pct;
  int receiver_stall_pct;
  int sent;
  int idle_cycles;
  bit timed_out;

  function automatic longint floor_shift(longint v, int k);
    return v >>> k;
  endfunction

  function automatic logic [31:0] lcg_step(logic [31:0] h);
    return h * 32'd1664525 + 32'd1013904223;
  endfunction

  function automatic logic [31:0] cell_hash(logic [31:0] cx, logic [31:0] cy);
    logic [31:0] h;
    logic [63:0] wide;
    logic [31:0] hi;
    wide = 64'(seed_reg) * 64'h9E3779B185EBCA87;
    hi = wide[63:32];
    h = lcg_step(cx);
    h = lcg_step(h ^ cy);
    h = lcg_step(h ^ seed_reg);
    h = lcg_step(h ^ hi);
    h = lcg_step(h);
    h ^= h >> 16;
    h *= 32'h7feb352d;
    h ^= h >> 15;
    h *= 32'h846ca68b;
    h ^= h >> 16;
    return h;
  endfunction

  function automatic longint gradient_dot(logic [1:0] sel, longint dx, longint dy);
    longint u, v, a, b;
    u = sel[1] ? dy : dx;
    v = sel[1] ? dx : dy;
    a = sel[0] ? -u : u;
    b = sel[1] ? -2 * v : 2 * v;
    return a + b;
  endfunction

  function automatic longint ease(longint f);
    longint f2;
    f2 = (f * f) >>> 16;
    return (f2 * (3 * 65536 - 2 * f)) >>> 16;
  endfunction

  function automatic longint mix(longint a, longint b, longint s);
    return a + floor_shift(s * (b - a), 16);
  endfunction

  // Predict one noise sample from a position and the shadow registers
  function automatic gln_pkg::noise_t predict_noise(gln_pkg::pos_t p);
    longint px, py, fx, fy, sx, sy, n, mag, prod;
    logic [31:0] x0, y0, x1, y1;
    gln_pkg::noise_t r;
    px = floor_shift((longint'(p.pos_x) + longint'(offx_reg)) * longint'(scale_reg), 16);
    py = floor_shift((longint'(p.pos_y) + longint'(offy_reg)) * longint'(scale_reg), 16);
    fx = px & 64'hFFFF;
    fy = py & 64'hFFFF;
    x0 = 32'(px >>> 16);
    y0 = 32'(py >>> 16);
    x1 = x0 + 32'd1;
    y1 = y0 + 32'd1;
    sx = ease(fx);
    sy = ease(fy);
    n = mix(mix(gradient_dot(2'(cell_hash(x0, y0)), fx, fy),
                gradient_dot(2'(cell_hash(x1, y0)), fx - 65536, fy), sx),
            mix(gradient_dot(2'(cell_hash(x0, y1)), fx, fy - 65536),
                gradient_dot(2'(cell_hash(x1, y1)), fx - 65536, fy - 65536), sx), sy);
    mag = n < 0 ? -n : n;
    if (mode_reg == gln_pkg::MODE_RIDGE) begin
      n = 65536 - 2 * mag;
    end else if (mode_reg == gln_pkg::MODE_BILLOW) begin
      n = mag + longint'(bias_reg) * 16;
      if (n > 65536) n = 65536;
      if (n < -65536) n = -65536;
    end
    prod = floor_shift(n * longint'(amp_reg), 16);
    r.saturated = 1'b0;
    if (prod > 32767) begin
      prod = 32767;
      r.saturated = 1'b1;
    end
    if (prod < -32768) begin
      prod = -32768;
      r.saturated = 1'b1;
    end
    r.noise_value = 16'(prod);
    return r;
  endfunction

  // Write one register and keep the shadow copy in step
  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      gln_pkg::CFG_SEED:        seed_reg = value;
      gln_pkg::CFG_SCALE:       scale_reg = value[23:0];
      gln_pkg::CFG_AMPLITUDE:   amp_reg = value[15:0];
      gln_pkg::CFG_NOISE_MODE:  mode_reg = value[1:0];
      gln_pkg::CFG_BILLOW_BIAS: bias_reg = value[15:0];
      gln_pkg::CFG_OFFSET_X:    offx_reg = value;
      gln_pkg::CFG_OFFSET_Y:    offy_reg = value;
      default: ;
    endcase
  endtask

  // Send one position request, idling first at random
  task automatic send_position(logic [31:0] x, logic [31:0] y);
    gln_pkg::pos_t p;
    while ($urandom_range(99) < sender_idle_pct) begin
      pos_valid <= 1'b0;
      @(posedge clk);
    end
    p.pos_x = x;
    p.pos_y = y;
    pos_valid <= 1'b1;
    pos <= p;
    do @(posedge clk); while (pos_stall);
    board.note_position(predict_noise(p));
    sent++;
  endtask

  task automatic wait_drained();
    pos_valid <= 1'b0;
    while (board.pending_samples.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic logic [31:0] random_coord();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(8 << 16)) - (4 << 16));
      2: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
      default: return $urandom_range(1) ? 32'h7FFF_FFFF - $urandom_range(65536 * 3)
                                        : 32'h8000_0000 + $urandom_range(65536 * 3);
    endcase
  endfunction

  // Receiver side: stall at random and check accepted samples
  always @(posedge clk) begin
    if (!rst) begin
      if (noise_valid && !noise_stall) board.check_sample(noise);
      noise_stall <= ($urandom_range(99) < receiver_stall_pct);
    end
  end

  // Watchdog on cycles with no accepted request or sample
  always @(posedge clk) begin
    if ((pos_valid && !pos_stall) || (noise_valid && !noise_stall) || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", idle_cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  int phase_idle[4] = '{0, 50, 0, 8};
  int phase_stall[4] = '{0, 0, 50, 8};

  initial begin
    board = new();
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    seed_reg = gln_pkg::SEED_RST;
    scale_reg = gln_pkg::SCALE_RST;
    amp_reg = gln_pkg::AMP_RST;
    mode_reg = gln_pkg::MODE_PLAIN;
    bias_reg = '0;
    offx_reg = '0;
    offy_reg = '0;
    idle_cycles = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: field extremes under reset settings, cell index wrap
    send_position(32'h0, 32'h0);
    send_position(32'h7FFF_FFFF, 32'h8000_0000);
    send_position(32'h8000_0000, 32'h7FFF_FFFF);
    send_position(32'hFFFF_FFFF, 32'h0000_FFFF);
    send_position(32'h0001_8000, 32'hFFFE_4000);
    write_wait();
    // Offset sum beyond 32 bits, large scale, saturating gain
    write_reg(gln_pkg::CFG_OFFSET_X, 32'h7FFF_FFFF);
    write_reg(gln_pkg::CFG_OFFSET_Y, 32'h8000_0000);
    write_reg(gln_pkg::CFG_SCALE, 32'h00FF_FFFF);
    write_reg(gln_pkg::CFG_AMPLITUDE, 32'h7FFF);
    send_position(32'h7FFF_FFFF, 32'h8000_0000);
    send_position(32'h1234_5678, 32'hFEDC_BA98);
    write_wait();
    // Every mode, the unused code too, with extreme gain and bias
    for (int m = 0; m < 4; m++) begin
      write_reg(gln_pkg::CFG_NOISE_MODE, 32'(m));
      write_reg(gln_pkg::CFG_AMPLITUDE, (m & 1) ? 32'hFFFF_8000 : 32'h7FFF);
      write_reg(gln_pkg::CFG_BILLOW_BIAS, (m & 2) ? 32'h7FFF : 32'hFFFF_8000);
      write_reg(gln_pkg::CFG_SEED, m[0] ? 32'hFFFF_FFFF : 32'h0);
      send_position(32'h0003_2000, 32'hFFFF_7000);
      send_position($urandom, $urandom);
      send_position(32'h8000_0000, 32'h8000_0000);
      write_wait();
    end
    write_reg(gln_pkg::CFG_SCALE, 32'h0);
    send_position(32'h0001_0000, 32'h0002_0000);
    write_wait();

    // Random phases over settings and idle patterns
    for (int ph = 0; ph < 16; ph++) begin
      sender_idle_pct = phase_idle[ph % 4];
      receiver_stall_pct = phase_stall[ph % 4];
      write_reg(gln_pkg::CFG_SEED, $urandom);
      write_reg(gln_pkg::CFG_SCALE,
                $urandom_range(3) == 0 ? $urandom : $urandom_range(1 << 19));
      write_reg(gln_pkg::CFG_AMPLITUDE, $urandom_range(1) ? $urandom : $urandom_range(8192));
      write_reg(gln_pkg::CFG_NOISE_MODE, $urandom_range(3));
      write_reg(gln_pkg::CFG_BILLOW_BIAS,
                $urandom_range(1) ? $urandom : 32'($urandom_range(8192)) - 4096);
      write_reg(gln_pkg::CFG_OFFSET_X, $urandom_range(1) ? $urandom : 32'h0);
      write_reg(gln_pkg::CFG_OFFSET_Y, $urandom_range(1) ? $urandom : 32'h0);
      for (int k = 0; k < 105; k++) send_position(random_coord(), random_coord());
      sender_idle_pct = 0;
      write_wait();
    end

    receiver_stall_pct = 0;
    $display("covered %0d positions over 4 shaping codes, random registers and idle phases",
             sent);
    $display("checked %0d samples, %0d mismatches", board.checked, board.mismatches);
    if (board.mismatches == 0 && board.pending_samples.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  task automatic write_wait();
    wait_drained();
  endtask
endmodule

// ===== filelist.f =====
rtl/gln_pkg.sv
rtl/gradient_lattice_noise_2d.sv
verif/testbench.sv
